// ===== rtl/srs_pkg.sv =====
// srs_pkg: shared types and constants for the selective-repeat sender window.
// No dependencies.
`default_nettype none
package srs_pkg;
  localparam int unsigned MaxWindow = 16;

  localparam logic [1:0] ActSend = 2'd0;
  localparam logic [1:0] ActAck  = 2'd1;
  localparam logic [1:0] ActTick = 2'd2;

  localparam logic [2:0] KindSent    = 3'd0;
  localparam logic [2:0] KindFull    = 3'd1;
  localparam logic [2:0] KindAck     = 3'd2;
  localparam logic [2:0] KindIgnored = 3'd3;
  localparam logic [2:0] KindRetx    = 3'd4;
  localparam logic [2:0] KindIdle    = 3'd5;
  localparam logic [2:0] KindLost    = 3'd6;
  localparam logic [2:0] KindDone    = 3'd7;

  localparam logic [1:0] RegWindow  = 2'd0;
  localparam logic [1:0] RegTimeout = 2'd1;
  localparam logic [1:0] RegIdle    = 2'd2;

  localparam int unsigned CfgW = 32;
  localparam logic [4:0] WindowReset = 5'd4;
  localparam logic [31:0] TimeoutReset = 32'd3000;
  localparam logic [31:0] IdleReset = 32'd100000;

  typedef struct packed {
    logic [1:0] action;
    logic       packet_is_last;
    logic       ack_flag;
    logic [4:0] ack_seq;
    logic       ack_final;
  } in_word_t;

  typedef struct packed {
    logic [2:0] result_kind;
    logic [4:0] seq_number;
    logic [3:0] buffer_slot;
    logic [4:0] slide_count;
    logic [4:0] window_base;
    logic       last_of_run;
  } out_word_t;
endpackage
`default_nettype wire

// ===== rtl/srs_if.sv =====
// srs_if: valid/ready channels carrying one srs_pkg input word or output word.
// Depends on srs_pkg for the payload types.
`default_nettype none
interface srs_in_if;
  logic              valid;
  logic              ready;
  srs_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface srs_out_if;
  logic               valid;
  logic               ready;
  srs_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/selective_repeat_sender_window_core.sv =====
// selective_repeat_sender_window_core: selective-repeat ARQ sender window.
// Flow: a send, refused send, ignored or non-sliding ack, or idle or lost tick loads its
//   word into the output register on acceptance; an ack of the base first walks the
//   slide state, and a tick first scans the window, stalling while a retransmit waits
//   at the output.
// Input: one word at a time; next word taken once the sequencer is idle and the
//   output register is empty.
// Reset: window empty, base 0, time 0, registers at their reset values.
`default_nettype none
module selective_repeat_sender_window_core #(
  parameter int unsigned TimeBits  = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  srs_in_if.sink                           in_if,
  srs_out_if.source                        out_if,
  input  wire logic                        cfg_we_i,
  input  wire logic [1:0]                  cfg_idx_i,
  input  wire logic [srs_pkg::CfgW-1:0]    cfg_data_i
);
  localparam int unsigned MaxWindow = srs_pkg::MaxWindow;
  localparam int unsigned Depth = 2 * MaxWindow;
  localparam int unsigned SW = $clog2(Depth);
  localparam int unsigned WW = $clog2(MaxWindow + 1);

  // Sequencer states.
  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSlide = 2'd1;
  localparam logic [1:0] StScan  = 2'd2;
  localparam logic [1:0] StOut   = 2'd3;

  logic [4:0]  win_reg_q;
  logic [31:0] timeout_q, idle_q;
  logic [1:0]  st_q;

  logic [SW-1:0] base_q, last_q;
  logic          any_q, lastq_q, fin_q;
  logic [TimeBits-1:0] now_q, ack_stamp_q;
  logic [SW-1:0] ptr_q;      // scan/slide position
  logic [WW-1:0] cnt_q;      // scan steps taken / slide count
  logic          held_q;     // a retransmit is held until the next hit or the scan end
  logic [SW-1:0] held_seq_q;
  logic          ov_q;       // output word valid
  srs_pkg::out_word_t ow_q;
  logic [SW-1:0] ack_seq_q;
  logic          ack_fin_q;

  // Effective window, 1..MaxWindow.
  logic [WW-1:0] w;
  logic [SW:0]   s;
  always_comb begin
    if (win_reg_q == 5'd0) w = WW'(1);
    else if (32'(win_reg_q) > MaxWindow) w = WW'(MaxWindow);
    else w = WW'(win_reg_q);
    s = (SW+1)'(w) << 1;
  end

  function automatic logic [SW-1:0] inc_mod(input logic [SW-1:0] a, input logic [SW:0] m);
    logic [SW:0] t;
    t = (SW+1)'(a) + 1'b1;
    return (t >= m) ? SW'(0) : t[SW-1:0];
  endfunction

  // Slot = seq mod w. Ignored acks may carry any value up to 31, so reduce with
  // five compare-and-subtract steps against w shifted down from 16w.
  function automatic logic [3:0] slot_of(input logic [4:0] q, input logic [WW-1:0] ww);
    logic [8:0] t, d;
    t = {4'd0, q};
    for (int k = 4; k >= 0; k--) begin
      d = 9'(ww) << k;
      if (t >= d) t = t - d;
    end
    return t[3:0];
  endfunction

  // Cell row.
  logic [Depth-1:0] c_send, c_ack, c_unack, c_stamp, c_acked, c_pend;
  logic [TimeBits-1:0] c_st [Depth];
  logic clear_all;

  for (genvar g = 0; g < Depth; g++) begin : g_cell
    srs_cell #(.TimeBits(TimeBits)) u_cell (
      .clk_i, .rst_ni, .clear_i(clear_all),
      .send_i(c_send[g]), .ack_i(c_ack[g]), .unack_i(c_unack[g]),
      .stamp_i(c_stamp[g]), .now_i(now_q),
      .acked_o(c_acked[g]), .pending_o(c_pend[g]), .stamp_o(c_st[g])
    );
  end

  srs_pkg::in_word_t iw;
  assign iw = in_if.data;
  logic acc;
  assign in_if.ready = (st_q == StIdle) && !ov_q;
  assign acc = in_if.valid && in_if.ready;
  assign clear_all = cfg_we_i && (cfg_idx_i == srs_pkg::RegWindow);

  logic [SW-1:0] nxt;
  logic [SW-1:0] outst, rel;
  logic [SW:0]   outst_raw, rel_raw;
  logic [TimeBits-1:0] now_inc;
  assign nxt = any_q ? inc_mod(last_q, s) : SW'(0);
  assign outst_raw = (SW+1)'(nxt) + s - (SW+1)'(base_q);
  assign outst = SW'((outst_raw >= s) ? outst_raw - s : outst_raw);
  assign rel_raw = (SW+1)'(iw.ack_seq[SW-1:0]) + s - (SW+1)'(base_q);
  assign rel = SW'((rel_raw >= s) ? rel_raw - s : rel_raw);
  assign now_inc = now_q + 1'b1;

  // Decisions for the word at the input.
  logic send_ok, ack_take, lost_now;
  assign send_ok  = !fin_q && !lastq_q && (outst < SW'(w));
  assign ack_take = !fin_q && iw.ack_flag && (6'(iw.ack_seq) < 6'(s)) && (rel < outst);
  assign lost_now = 64'(now_inc - ack_stamp_q) > 64'(idle_q);

  logic scan_hit;
  logic [TimeBits-1:0] age;
  assign age = now_q - c_st[ptr_q];
  assign scan_hit = c_pend[ptr_q] && !c_acked[ptr_q] && (64'(age) > 64'(timeout_q));

  // Slide continues while the slot under the pointer is acked.
  logic slide_more;
  assign slide_more = c_acked[ptr_q] && ((SW+1)'(cnt_q) < s);

  // Scan stalls while a previous word waits at the output.
  logic out_fire_blk;
  assign out_fire_blk = ov_q && !out_if.ready;

  assign out_if.valid = ov_q;
  assign out_if.data  = ow_q;

  function automatic srs_pkg::out_word_t mk(input logic [2:0] k, input logic [4:0] q,
      input logic [4:0] sl, input logic [4:0] b, input logic l, input logic [WW-1:0] ww);
    srs_pkg::out_word_t r;
    r.result_kind = k;
    r.seq_number  = q;
    r.buffer_slot = (k == srs_pkg::KindIdle || k == srs_pkg::KindLost) ? 4'd0 : slot_of(q, ww);
    r.slide_count = sl;
    r.window_base = b;
    r.last_of_run = l;
    return r;
  endfunction

  always_comb begin
    c_send = '0; c_ack = '0; c_unack = '0; c_stamp = '0;
    if (acc && iw.action == srs_pkg::ActSend && send_ok) c_send[nxt] = 1'b1;
    if (acc && iw.action == srs_pkg::ActAck && ack_take) c_ack[iw.ack_seq[SW-1:0]] = 1'b1;
    // Slide: clear each acked slot passed.
    if (st_q == StSlide && slide_more) c_unack[ptr_q] = 1'b1;
    if (st_q == StScan && !out_fire_blk && scan_hit) c_stamp[ptr_q] = 1'b1;
  end

  // Load the output register this cycle.
  logic ov_load;
  always_comb begin
    ov_load = 1'b0;
    unique case (st_q)
      StIdle: if (acc) begin
        unique case (iw.action)
          srs_pkg::ActSend: ov_load = 1'b1;
          srs_pkg::ActAck:  ov_load = !(ack_take && iw.ack_seq[SW-1:0] == base_q);
          srs_pkg::ActTick: ov_load = fin_q || lost_now;
          default: ;
        endcase
      end
      StSlide: ov_load = !slide_more;
      StScan:  ov_load = !out_fire_blk && scan_hit && held_q;
      StOut:   ov_load = !out_fire_blk;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_reg_q <= srs_pkg::WindowReset;
      timeout_q <= srs_pkg::TimeoutReset;
      idle_q    <= srs_pkg::IdleReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        srs_pkg::RegWindow:  win_reg_q <= cfg_data_i[4:0];
        srs_pkg::RegTimeout: timeout_q <= cfg_data_i;
        srs_pkg::RegIdle:    idle_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; base_q <= '0; last_q <= '0; any_q <= 1'b0; lastq_q <= 1'b0;
      fin_q <= 1'b0; now_q <= '0; ack_stamp_q <= '0; ptr_q <= '0; cnt_q <= '0;
      held_q <= 1'b0; held_seq_q <= '0; ov_q <= 1'b0; ow_q <= '0;
      ack_seq_q <= '0; ack_fin_q <= 1'b0;
    end else begin
      // Hold the word until taken; a new one may load as the old one leaves.
      ov_q <= ov_load || out_fire_blk;
      if (clear_all) begin
        base_q <= '0; last_q <= '0; any_q <= 1'b0; lastq_q <= 1'b0; fin_q <= 1'b0;
      end else begin
        unique case (st_q)
          StIdle: if (acc) begin
            unique case (iw.action)
              srs_pkg::ActSend: begin
                if (!send_ok) begin
                  ow_q <= mk(srs_pkg::KindFull, 5'(nxt), 5'd0, 5'(base_q), 1'b1, w);
                end else begin
                  last_q <= nxt; any_q <= 1'b1;
                  if (iw.packet_is_last) lastq_q <= 1'b1;
                  ow_q <= mk(srs_pkg::KindSent, 5'(nxt), 5'd0, 5'(base_q), 1'b1, w);
                end
              end
              srs_pkg::ActAck: begin
                if (fin_q || !iw.ack_flag) begin
                  ow_q <= mk(srs_pkg::KindIgnored, iw.ack_seq, 5'd0, 5'(base_q), 1'b1, w);
                end else begin
                  ack_stamp_q <= now_q;
                  if (!ack_take) begin
                    ow_q <= mk(srs_pkg::KindIgnored, iw.ack_seq, 5'd0, 5'(base_q), 1'b1, w);
                  end else if (iw.ack_seq[SW-1:0] == base_q) begin
                    // Walk the ring clearing consecutive acked slots.
                    ack_seq_q <= iw.ack_seq[SW-1:0]; ack_fin_q <= iw.ack_final;
                    ptr_q <= base_q; cnt_q <= '0; st_q <= StSlide;
                  end else begin
                    if (iw.ack_final) fin_q <= 1'b1;
                    ow_q <= mk(iw.ack_final ? srs_pkg::KindDone : srs_pkg::KindAck,
                               iw.ack_seq, 5'd0, 5'(base_q), 1'b1, w);
                  end
                end
              end
              srs_pkg::ActTick: begin
                now_q <= now_inc;
                if (fin_q) begin
                  ow_q <= mk(srs_pkg::KindIdle, 5'd0, 5'd0, 5'(base_q), 1'b1, w);
                end else if (lost_now) begin
                  fin_q <= 1'b1;
                  ow_q <= mk(srs_pkg::KindLost, 5'd0, 5'd0, 5'(base_q), 1'b1, w);
                end else begin
                  ptr_q <= base_q; cnt_q <= '0; held_q <= 1'b0; st_q <= StScan;
                end
              end
              default: ;
            endcase
          end
          StSlide: begin
            // Advance one slot a cycle while the slot under the pointer is acked.
            if (slide_more) begin
              ptr_q <= inc_mod(ptr_q, s); cnt_q <= cnt_q + 1'b1;
            end else begin
              base_q <= ptr_q; st_q <= StIdle;
              if (ack_fin_q) fin_q <= 1'b1;
              ow_q <= mk(ack_fin_q ? srs_pkg::KindDone : srs_pkg::KindAck, 5'(ack_seq_q),
                         5'(cnt_q), 5'(ptr_q), 1'b1, w);
            end
          end
          StScan: if (!out_fire_blk) begin
            // Release the held retransmit once another one follows it.
            if (scan_hit) begin
              if (held_q) begin
                ow_q <= mk(srs_pkg::KindRetx, 5'(held_seq_q), 5'd0, 5'(base_q), 1'b0, w);
              end
              held_q <= 1'b1; held_seq_q <= ptr_q;
            end
            if (cnt_q == w - 1'b1) st_q <= StOut;
            ptr_q <= inc_mod(ptr_q, s); cnt_q <= cnt_q + 1'b1;
          end
          StOut: if (!out_fire_blk) begin
            // Close the run: the held retransmit is the last one, else report idle.
            if (held_q) begin
              ow_q <= mk(srs_pkg::KindRetx, 5'(held_seq_q), 5'd0, 5'(base_q), 1'b1, w);
            end else begin
              ow_q <= mk(srs_pkg::KindIdle, 5'd0, 5'd0, 5'(base_q), 1'b1, w);
            end
            st_q <= StIdle;
          end
          default: st_q <= StIdle;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/srs_cell.sv =====
// srs_cell: one sequence slot of the ring; holds its acked/pending bits and
// send stamp. No dependencies.
`default_nettype none
module srs_cell #(
  parameter int unsigned TimeBits = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                clear_i,
  input  wire logic                send_i,
  input  wire logic                ack_i,
  input  wire logic                unack_i,
  input  wire logic                stamp_i,
  input  wire logic [TimeBits-1:0] now_i,
  output      logic                acked_o,
  output      logic                pending_o,
  output      logic [TimeBits-1:0] stamp_o
);
  logic acked_q, pending_q;
  logic [TimeBits-1:0] stamp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q   <= 1'b0;
      pending_q <= 1'b0;
    end else if (clear_i) begin
      acked_q   <= 1'b0;
      pending_q <= 1'b0;
    end else if (send_i) begin
      acked_q   <= 1'b0;
      pending_q <= 1'b1;
    end else if (ack_i) begin
      acked_q   <= 1'b1;
      pending_q <= 1'b0;
    end else if (unack_i) begin
      acked_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (send_i || stamp_i) stamp_q <= now_i;
  end

  assign acked_o   = acked_q;
  assign pending_o = pending_q;
  assign stamp_o   = stamp_q;
endmodule
`default_nettype wire

// ===== tb/srs_tb_if.sv =====
`timescale 1ns / 100ps
// Testbench-side note: the channel interfaces come from rtl/srs_if.sv.
// This file only holds the shared ack-word helper used by tb.sv; depends on srs_pkg.
package srs_tb_pkg;

  // Pack one ack word; keeps the stimulus code short.
  function automatic srs_pkg::in_word_t mk_ack(logic flag, logic [4:0] seq, logic fin);
    srs_pkg::in_word_t w;
    w = '0;
    w.action = srs_pkg::ActAck;
    w.ack_flag = flag;
    w.ack_seq = seq;
    w.ack_final = fin;
    return w;
  endfunction
endpackage

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// tb: self-checking bench for selective_repeat_sender_window_core.
// Drives sends, acks and ticks through the srs_in_if/srs_out_if channels, predicts every
// result word in-bench and compares whole words. Depends on srs_pkg, srs_tb_pkg, srs_if.
module tb;
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = srs_pkg::RegWindow;
  logic [srs_pkg::CfgW-1:0] cfg_data_i = '0;

  srs_in_if in_ch ();
  srs_out_if out_ch ();

  selective_repeat_sender_window_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_ch.sink), .out_if(out_ch.source),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Window predictor: own copy of the sender state and registers.
  // ---------------------------------------------------------------------------
  logic [4:0]  win_reg;
  logic [31:0] retry_reg, idle_reg;
  logic [4:0]  base_q, last_sent_q;
  logic        any_sent_q, last_queued_q, finished_q;
  logic [31:0] acked_q, pending_q;
  logic [31:0] stamp_q [32];
  logic [31:0] now_q, last_ack_q;

  srs_pkg::out_word_t expected_words[$];

  // Counters and run control
  int mismatches = 0;
  longint cycles = 0;
  event blackout_go;           // start a long receiver blackout
  bit blackout = 1'b0;
  bit idle_free = 1'b0;        // stretch with no random idling on either side
  bit done_sending = 1'b0;

  function automatic int eff_window();
    if (win_reg == 0) return 1;
    if (win_reg > srs_pkg::MaxWindow) return int'(srs_pkg::MaxWindow);
    return int'(win_reg);
  endfunction

  function automatic void restart_window();
    base_q = '0; last_sent_q = '0; any_sent_q = 0; last_queued_q = 0;
    finished_q = 0; acked_q = '0; pending_q = '0;
  endfunction

  // Queue one predicted word; slot and base follow the current state.
  function automatic void push_word(logic [2:0] kind, int seq, int slide, logic last);
    srs_pkg::out_word_t o;
    o.result_kind = kind;
    o.seq_number = seq[4:0];
    o.buffer_slot = (kind == srs_pkg::KindIdle || kind == srs_pkg::KindLost) ? 4'd0
                    : 4'((seq % eff_window()) & 15);
    o.slide_count = slide[4:0];
    o.window_base = base_q;
    o.last_of_run = last;
    expected_words.push_back(o);
  endfunction

  // Advance the predictor by one accepted input word.
  function automatic void predict_window(srs_pkg::in_word_t w);
    int win, sp, nxt, outst, seq, slide, n, q;
    win = eff_window();
    sp = 2 * win;
    nxt = any_sent_q ? (int'(last_sent_q) + 1) % sp : 0;
    outst = (nxt + sp - int'(base_q)) % sp;
    case (w.action)
      srs_pkg::ActSend: begin
        if (finished_q || last_queued_q || outst >= win) begin
          push_word(srs_pkg::KindFull, nxt, 0, 1'b1);
        end else begin
          acked_q[nxt] = 0; pending_q[nxt] = 1; stamp_q[nxt] = now_q;
          last_sent_q = nxt[4:0]; any_sent_q = 1;
          if (w.packet_is_last) last_queued_q = 1;
          push_word(srs_pkg::KindSent, nxt, 0, 1'b1);
        end
      end
      srs_pkg::ActAck: begin
        seq = int'(w.ack_seq);
        slide = 0;
        if (finished_q || !w.ack_flag) begin
          push_word(srs_pkg::KindIgnored, seq, 0, 1'b1);
        end else begin
          last_ack_q = now_q;
          if (seq >= sp || ((seq + sp - int'(base_q)) % sp) >= outst) begin
            push_word(srs_pkg::KindIgnored, seq, 0, 1'b1);
          end else begin
            acked_q[seq] = 1; pending_q[seq] = 0;
            if (seq == int'(base_q)) begin
              while (slide < sp && acked_q[(int'(base_q) + slide) % sp]) begin
                acked_q[(int'(base_q) + slide) % sp] = 0;
                slide++;
              end
              base_q = 5'((int'(base_q) + slide) % sp);
            end
            if (w.ack_final) begin
              finished_q = 1;
              push_word(srs_pkg::KindDone, seq, slide, 1'b1);
            end else begin
              push_word(srs_pkg::KindAck, seq, slide, 1'b1);
            end
          end
        end
      end
      srs_pkg::ActTick: begin
        n = 0;
        now_q = now_q + 32'd1;
        if (finished_q) begin
          push_word(srs_pkg::KindIdle, 0, 0, 1'b1);
        end else if ((now_q - last_ack_q) > idle_reg) begin
          finished_q = 1;
          push_word(srs_pkg::KindLost, 0, 0, 1'b1);
        end else begin
          for (int i = 0; i < win; i++) begin
            q = (int'(base_q) + i) % sp;
            if (pending_q[q] && !acked_q[q] && (now_q - stamp_q[q]) > retry_reg) begin
              stamp_q[q] = now_q;
              push_word(srs_pkg::KindRetx, q, 0, 1'b0);
              n++;
            end
          end
          if (n == 0) push_word(srs_pkg::KindIdle, 0, 0, 1'b1);
          else expected_words[expected_words.size() - 1].last_of_run = 1'b1;
        end
      end
      default: ;  // unused code: no result
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
  end

  // Offer one word, idling at random first; hold until accepted. Valid stays
  // high after acceptance so a following word can be offered back to back.
  task automatic send_word(srs_pkg::in_word_t w);
    while (!idle_free && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_window(w);
  endtask

  // Drop valid, drain all expected words, then let the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      srs_pkg::RegWindow: begin win_reg = val[4:0]; restart_window(); end
      srs_pkg::RegTimeout: retry_reg = val;
      srs_pkg::RegIdle: idle_reg = val;
      default: ;
    endcase
  endtask

  function automatic srs_pkg::in_word_t mk_send(logic last);
    srs_pkg::in_word_t w;
    w = '0;
    w.action = srs_pkg::ActSend;
    w.packet_is_last = last;
    return w;
  endfunction

  function automatic srs_pkg::in_word_t mk_tick();
    srs_pkg::in_word_t w;
    w = 10'($urandom);
    w.action = srs_pkg::ActTick;
    return w;
  endfunction

  // A random outstanding sequence number, or any random number when nothing is out.
  function automatic logic [4:0] pick_seq();
    int sp, outst, nxt;
    sp = 2 * eff_window();
    nxt = any_sent_q ? (int'(last_sent_q) + 1) % sp : 0;
    outst = (nxt + sp - int'(base_q)) % sp;
    if (outst == 0) return 5'($urandom);
    return 5'((int'(base_q) + $urandom_range(outst - 1)) % sp);
  endfunction

  // Directed: field extremes, every action, full window, last, final ack, lost.
  task automatic test_directed();
    srs_pkg::in_word_t w;
    write_reg(srs_pkg::RegWindow, 32'd1);
    write_reg(srs_pkg::RegTimeout, 32'd1);
    write_reg(srs_pkg::RegIdle, 32'd6);
    send_word(mk_send(1'b0));             // seq 0
    send_word(mk_send(1'b0));             // window full
    send_word(srs_tb_pkg::mk_ack(1'b0, 5'd0, 1'b0));  // no flag
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd31, 1'b1)); // out of space
    send_word(mk_tick());
    send_word(mk_tick());                 // retransmit
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd0, 1'b0));  // slide 1
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd0, 1'b0));  // not outstanding now
    w = '1;                               // unused action code, no result
    send_word(w);
    repeat (8) send_word(mk_tick());      // goes lost
    send_word(mk_send(1'b0));
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd1, 1'b0));
    wait_drained();
    write_reg(srs_pkg::RegWindow, 32'd31);         // clamps to 16
    write_reg(srs_pkg::RegIdle, 32'hFFFF_FFFF);
    write_reg(srs_pkg::RegTimeout, 32'hFFFF_FFFF);
    send_word(mk_send(1'b0));
    send_word(mk_send(1'b1));             // last queued
    send_word(mk_send(1'b0));             // refused after last
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd1, 1'b0));
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd0, 1'b0));  // slide 2
    send_word(srs_tb_pkg::mk_ack(1'b1, 5'd1, 1'b1));  // ignored: no longer outstanding
    wait_drained();
  endtask

  // Random phases over several window/timeout settings, mostly well-formed flow.
  task automatic test_random(int count);
    int r, wsel;
    srs_pkg::in_word_t w;
    for (int ph = 0; ph < 8; ph++) begin
      wsel = (ph == 0) ? 16 : (ph == 1) ? 0 : $urandom_range(1, 16);
      write_reg(srs_pkg::RegWindow, wsel);
      write_reg(srs_pkg::RegTimeout, $urandom_range(1, 6));
      write_reg(srs_pkg::RegIdle, (ph == 3) ? 32'd4 : $urandom_range(15, 60));
      for (int k = 0; k < count / 8; k++) begin
        r = $urandom_range(99);
        if (r < 35) send_word(mk_send($urandom_range(99) < 3));
        else if (r < 65) begin
          send_word(srs_tb_pkg::mk_ack(1'b1, pick_seq(), $urandom_range(99) < 2));
        end else if (r < 90) send_word(mk_tick());
        else begin
          w = 10'($urandom);
          send_word(w);
        end
      end
      wait_drained();
    end
  endtask

  // Pressure: receiver blacks out while ticks with many retransmits queue up,
  // then the sender pauses until every expected word is back.
  task automatic test_backpressure();
    write_reg(srs_pkg::RegWindow, 32'd16);
    write_reg(srs_pkg::RegTimeout, 32'd1);
    write_reg(srs_pkg::RegIdle, 32'd1000);
    idle_free = 1'b1;
    repeat (16) send_word(mk_send(1'b0));
    -> blackout_go;
    repeat (6) send_word(mk_tick());
    wait_drained();
    repeat (20) begin
      if ($urandom_range(1)) send_word(mk_tick());
      else send_word(srs_tb_pkg::mk_ack(1'b1, pick_seq(), 1'b0));
    end
    idle_free = 1'b0;
    wait_drained();
  endtask

  initial begin
    win_reg = srs_pkg::WindowReset;
    retry_reg = srs_pkg::TimeoutReset;
    idle_reg = srs_pkg::IdleReset;
    restart_window();
    for (int i = 0; i < 32; i++) stamp_q[i] = '0;
    now_q = '0; last_ack_q = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(256);
    done_sending = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, long blackout on request.
  // ---------------------------------------------------------------------------
  initial out_ch.ready = 1'b0;

  // Blackout length counted here in cycles.
  initial begin
    forever begin
      @(blackout_go);
      blackout <= 1'b1;
      repeat (300) @(posedge clk_i);
      blackout <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= !blackout && (idle_free || ($urandom_range(99) >= 23));
  end

  // Check each accepted result word against the oldest expectation.
  always @(posedge clk_i) begin : chk
    srs_pkg::out_word_t exp_w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", out_ch.data);
      end else begin
        exp_w = expected_words.pop_front();
        if (out_ch.data !== exp_w) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_w, out_ch.data);
        end
      end
    end
  end

  // End of run: drain, settle, report; the cycle limit catches hangs.
  initial begin
    wait (done_sending);
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule
